FILE: design/nsb_pkg.sv
// Shared widths, operation codes and control types of the nearest-site event binner.
package nsb_pkg;

   localparam int SIU_W     = 5;
   localparam int OP_W      = 2;
   localparam int LAT_W     = 28;
   localparam int LNG_W     = 29;
   localparam int KIND_W    = 2;
   localparam int TIME_W    = 48;
   localparam int SITE_W    = 4;
   localparam int OUT_CNT_W = 16;
   localparam int PCT_W     = 7;

   // Distance arithmetic: coordinate difference, its magnitude, square and sum of squares.
   localparam int DIFF_W = LNG_W + 1;
   localparam int MAG_W  = LNG_W;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int DIST_W = SQ_W + 1;

   // For a nonzero total, percent below one hundred is fifty plus a quotient below fifty.
   localparam int QUO_W  = 6;
   localparam int STEP_W = 3;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
   localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;

   localparam logic [OP_W-1:0] OP_EVENT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic [KIND_W-1:0] KIND_TEMP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VIB  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INTR = 2'd2;

   typedef struct packed {
      logic en;
      logic use_lng;
   } dist_ctrl_type;

   typedef struct packed {
      logic             done;
      logic [PCT_W-1:0] pct;
   } pct_status_type;

endpackage

FILE: design/nsb_if.sv
// Request and response channel interfaces of the nearest-site event binner.
interface nsb_req_if;
   import nsb_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [LAT_W-1:0]  latitude;
   logic signed [LNG_W-1:0]  longitude;
   logic [KIND_W-1:0]        kind;
   logic                     is_high;
   logic [TIME_W-1:0]        event_time;
   logic [SITE_W-1:0]        site_index;

   modport source (
      output valid, op, latitude, longitude, kind, is_high, event_time, site_index,
      input  ready
   );
   modport sink (
      input  valid, op, latitude, longitude, kind, is_high, event_time, site_index,
      output ready
   );
endinterface

interface nsb_rsp_if;
   import nsb_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 matched;
   logic [SITE_W-1:0]    site;
   logic [OUT_CNT_W-1:0] temp_count;
   logic [OUT_CNT_W-1:0] vib_count;
   logic [OUT_CNT_W-1:0] intr_count;
   logic [OUT_CNT_W-1:0] high_count;
   logic [TIME_W-1:0]    latest_time;
   logic [PCT_W-1:0]     risk_percent;

   modport source (
      output valid, matched, site, temp_count, vib_count, intr_count, high_count,
             latest_time, risk_percent,
      input  ready
   );
   modport sink (
      input  valid, matched, site, temp_count, vib_count, intr_count, high_count,
             latest_time, risk_percent,
      output ready
   );
endinterface

FILE: design/nearest_site_event_binner_top.sv
// Top level of the nearest-site event binner: sequencer, site tables and result register.
//
// Each request beat is one operation. An event beat is binned to the loaded site with the
// least squared distance (lower index wins a tie) among the first sites_in_use entries;
// that site's kind counter, high-level counter and latest timestamp are updated and its
// statistics are returned. A load beat writes one site's coordinates, a query beat reads
// one site's statistics; both return the site's counters and risk percent. The block
// takes one beat at a time. An event scans the sites in use in order: one shared 29 x 29
// squaring unit handles the latitude and longitude difference of each site in turn,
// followed by a sum-and-compare step; the statistics update and the six-step risk
// percent divider follow. A load or query goes straight to the statistics step and the
// six-step risk percent divider. An event with no sites in use, and an unused operation
// code, return a beat with matched low and all fields zero. The response beat sits in an
// output register, so the sequencer keeps working while the previous beat waits for
// rsp_chan.ready. Site coordinates must be loaded before they are searched or queried;
// the counters and timestamps start cleared. sites_in_use may be written only while no
// beat is in flight.
module nearest_site_event_binner_top #(
   parameter int MAX_SITES  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   nsb_req_if.sink                      req_chan,
   nsb_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [nsb_pkg::SIU_W-1:0]    csr_wr_data
);
   import nsb_pkg::*;

   localparam int IDX_W  = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
   localparam int SCAN_W = (IDX_W > SIU_W) ? IDX_W : SIU_W;
   localparam int LIMIT  = (MAX_SITES < 31) ? MAX_SITES : 31;
   localparam int TOT_W  = COUNT_BITS + 2;
   localparam logic [SIU_W-1:0]      LIMIT_V = SIU_W'(LIMIT);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_LAT  = 7'b0000010,
      ST_LNG  = 7'b0000100,
      ST_CMP  = 7'b0001000,
      ST_STAT = 7'b0010000,
      ST_PCT  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [SIU_W-1:0] siu_ff;

   // Latched request.
   logic [OP_W-1:0]         op_ff,   op_in;
   logic signed [LAT_W-1:0] lat_ff,  lat_in;
   logic signed [LNG_W-1:0] lng_ff,  lng_in;
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic                    high_ff, high_in;
   logic [TIME_W-1:0]       time_ff, time_in;

   // Scan and search state.
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic [SCAN_W-1:0] last_ff, last_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]  stat_addr_ff, stat_addr_in;
   logic              in_range_ff, in_range_in;

   // Result held until the output register is free.
   logic                 res_matched_ff, res_matched_in;
   logic [SITE_W-1:0]    res_site_ff,    res_site_in;
   logic [OUT_CNT_W-1:0] res_temp_ff,    res_temp_in;
   logic [OUT_CNT_W-1:0] res_vib_ff,     res_vib_in;
   logic [OUT_CNT_W-1:0] res_intr_ff,    res_intr_in;
   logic [OUT_CNT_W-1:0] res_high_ff,    res_high_in;
   logic [TIME_W-1:0]    res_time_ff,    res_time_in;
   logic [PCT_W-1:0]     res_pct_ff,     res_pct_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_matched_ff;
   logic [SITE_W-1:0]    rsp_site_ff;
   logic [OUT_CNT_W-1:0] rsp_temp_ff, rsp_vib_ff, rsp_intr_ff, rsp_high_ff;
   logic [TIME_W-1:0]    rsp_time_ff;
   logic [PCT_W-1:0]     rsp_pct_ff;
   logic                 rsp_load;

   // Site tables.
   logic signed [LAT_W-1:0] lat_mem [MAX_SITES];
   logic signed [LNG_W-1:0] lng_mem [MAX_SITES];
   logic signed [LAT_W-1:0] lat_rd_ff;
   logic signed [LNG_W-1:0] lng_rd_ff;
   logic                    coord_we;
   logic [IDX_W-1:0]        coord_addr;

   logic [COUNT_BITS-1:0] temp_mem [MAX_SITES];
   logic [COUNT_BITS-1:0] vib_mem  [MAX_SITES];
   logic [COUNT_BITS-1:0] intr_mem [MAX_SITES];
   logic [COUNT_BITS-1:0] high_mem [MAX_SITES];
   logic [TIME_W-1:0]     time_mem [MAX_SITES];
   logic [MAX_SITES-1:0]  stat_vld_ff;
   logic [COUNT_BITS-1:0] temp_rd_ff, vib_rd_ff, intr_rd_ff, high_rd_ff;
   logic [TIME_W-1:0]     time_rd_ff;
   logic                  vld_rd_ff;
   logic                  stat_we;

   // Working signals.
   logic                  req_accept;
   logic [SIU_W-1:0]      n_sites;
   logic [IDX_W+SITE_W-1:0] idx_ext;
   logic [IDX_W-1:0]      idx_addr;
   logic                  idx_ok;
   logic [IDX_W+SITE_W-1:0] best_ext;
   logic                  closer;
   logic                  stat_hit;
   logic                  is_event;
   logic [COUNT_BITS-1:0] cur_temp, cur_vib, cur_intr, cur_high;
   logic [TIME_W-1:0]     cur_time;
   logic [COUNT_BITS-1:0] new_temp, new_vib, new_intr, new_high;
   logic [TIME_W-1:0]     new_time;
   logic [COUNT_BITS+OUT_CNT_W-1:0] temp_ext, vib_ext, intr_ext, high_ext;
   logic [TOT_W-1:0]      total;

   dist_ctrl_type         dist_ctrl;
   logic [DIST_W-1:0]     dist_sum;
   logic                  pct_start;
   pct_status_type        pct_status;

   nsb_dist_unit u_dist (
      .clock    (clock),
      .ctrl     (dist_ctrl),
      .ev_lat   (lat_ff),
      .ev_lng   (lng_ff),
      .site_lat (lat_rd_ff),
      .site_lng (lng_rd_ff),
      .dist_sum (dist_sum)
   );

   nsb_pct_unit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_pct (
      .clock  (clock),
      .reset  (reset),
      .start  (pct_start),
      .total  (total),
      .high   (new_high),
      .status (pct_status)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && (state_ff == ST_IDLE);

   // Number of entries searched: the register, limited to the table depth.
   assign n_sites = (siu_ff > LIMIT_V) ? LIMIT_V : siu_ff;

   assign idx_ext  = {{IDX_W{1'b0}}, req_chan.site_index};
   assign idx_addr = idx_ext[IDX_W-1:0];
   assign idx_ok   = (32'(req_chan.site_index) < MAX_SITES);

   assign closer   = (scan_ff == '0) || (dist_sum < best_dist_ff);
   assign best_ext = {{SITE_W{1'b0}}, best_in};

   // Statistics of the addressed site, then the event update applied to them.
   always_comb begin
      stat_hit = in_range_ff && vld_rd_ff;
      is_event = (op_ff == OP_EVENT);
      cur_temp = stat_hit ? temp_rd_ff : '0;
      cur_vib  = stat_hit ? vib_rd_ff  : '0;
      cur_intr = stat_hit ? intr_rd_ff : '0;
      cur_high = stat_hit ? high_rd_ff : '0;
      cur_time = stat_hit ? time_rd_ff : '0;

      new_temp = cur_temp;
      new_vib  = cur_vib;
      new_intr = cur_intr;
      new_high = cur_high;
      new_time = cur_time;
      if (is_event) begin
         if (kind_ff == KIND_TEMP && cur_temp != CNT_MAX) begin
            new_temp = cur_temp + 1'b1;
         end
         if (kind_ff == KIND_VIB && cur_vib != CNT_MAX) begin
            new_vib = cur_vib + 1'b1;
         end
         if (kind_ff == KIND_INTR && cur_intr != CNT_MAX) begin
            new_intr = cur_intr + 1'b1;
         end
         if (high_ff && cur_high != CNT_MAX) begin
            new_high = cur_high + 1'b1;
         end
         if (time_ff > cur_time) begin
            new_time = time_ff;
         end
      end

      temp_ext = {{OUT_CNT_W{1'b0}}, new_temp};
      vib_ext  = {{OUT_CNT_W{1'b0}}, new_vib};
      intr_ext = {{OUT_CNT_W{1'b0}}, new_intr};
      high_ext = {{OUT_CNT_W{1'b0}}, new_high};
      total    = TOT_W'(new_temp) + TOT_W'(new_vib) + TOT_W'(new_intr);
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      lat_in         = lat_ff;
      lng_in         = lng_ff;
      kind_in        = kind_ff;
      high_in        = high_ff;
      time_in        = time_ff;
      scan_in        = scan_ff;
      last_in        = last_ff;
      best_in        = best_ff;
      best_dist_in   = best_dist_ff;
      stat_addr_in   = stat_addr_ff;
      in_range_in    = in_range_ff;
      res_matched_in = res_matched_ff;
      res_site_in    = res_site_ff;
      res_temp_in    = res_temp_ff;
      res_vib_in     = res_vib_ff;
      res_intr_in    = res_intr_ff;
      res_high_in    = res_high_ff;
      res_time_in    = res_time_ff;
      res_pct_in     = res_pct_ff;
      coord_we       = 1'b0;
      stat_we        = 1'b0;
      pct_start      = 1'b0;
      dist_ctrl      = '0;
      rsp_load       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in   = req_chan.op;
               lat_in  = req_chan.latitude;
               lng_in  = req_chan.longitude;
               kind_in = req_chan.kind;
               high_in = req_chan.is_high;
               time_in = req_chan.event_time;
               unique case (req_chan.op)
                  OP_EVENT: begin
                     if (n_sites == '0) begin
                        // Nothing to bin against: the event is dropped.
                        res_matched_in = 1'b0;
                        res_site_in    = '0;
                        res_temp_in    = '0;
                        res_vib_in     = '0;
                        res_intr_in    = '0;
                        res_high_in    = '0;
                        res_time_in    = '0;
                        res_pct_in     = '0;
                        state_in       = ST_OUT;
                     end else begin
                        scan_in  = '0;
                        last_in  = SCAN_W'(n_sites) - 1'b1;
                        state_in = ST_LAT;
                     end
                  end
                  OP_LOAD, OP_QUERY: begin
                     coord_we       = (req_chan.op == OP_LOAD) && idx_ok;
                     stat_addr_in   = idx_addr;
                     in_range_in    = idx_ok;
                     res_matched_in = 1'b1;
                     res_site_in    = req_chan.site_index;
                     state_in       = ST_STAT;
                  end
                  default: begin
                     res_matched_in = 1'b0;
                     res_site_in    = '0;
                     res_temp_in    = '0;
                     res_vib_in     = '0;
                     res_intr_in    = '0;
                     res_high_in    = '0;
                     res_time_in    = '0;
                     res_pct_in     = '0;
                     state_in       = ST_OUT;
                  end
               endcase
            end
         end
         ST_LAT: begin
            dist_ctrl.en      = 1'b1;
            dist_ctrl.use_lng = 1'b0;
            state_in          = ST_LNG;
         end
         ST_LNG: begin
            dist_ctrl.en      = 1'b1;
            dist_ctrl.use_lng = 1'b1;
            state_in          = ST_CMP;
         end
         ST_CMP: begin
            if (closer) begin
               best_in      = scan_ff[IDX_W-1:0];
               best_dist_in = dist_sum;
            end
            if (scan_ff == last_ff) begin
               stat_addr_in   = best_in;
               in_range_in    = 1'b1;
               res_matched_in = 1'b1;
               res_site_in    = best_ext[SITE_W-1:0];
               state_in       = ST_STAT;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = ST_LAT;
            end
         end
         ST_STAT: begin
            stat_we     = is_event;
            pct_start   = 1'b1;
            res_temp_in = temp_ext[OUT_CNT_W-1:0];
            res_vib_in  = vib_ext[OUT_CNT_W-1:0];
            res_intr_in = intr_ext[OUT_CNT_W-1:0];
            res_high_in = high_ext[OUT_CNT_W-1:0];
            res_time_in = new_time;
            state_in    = ST_PCT;
         end
         ST_PCT: begin
            if (pct_status.done) begin
               res_pct_in = pct_status.pct;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The coordinate table is read at the scan index the next cycle works on.
   assign coord_addr = scan_in[IDX_W-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         siu_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            siu_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      lat_ff         <= lat_in;
      lng_ff         <= lng_in;
      kind_ff        <= kind_in;
      high_ff        <= high_in;
      time_ff        <= time_in;
      scan_ff        <= scan_in;
      last_ff        <= last_in;
      best_ff        <= best_in;
      best_dist_ff   <= best_dist_in;
      stat_addr_ff   <= stat_addr_in;
      in_range_ff    <= in_range_in;
      res_matched_ff <= res_matched_in;
      res_site_ff    <= res_site_in;
      res_temp_ff    <= res_temp_in;
      res_vib_ff     <= res_vib_in;
      res_intr_ff    <= res_intr_in;
      res_high_ff    <= res_high_in;
      res_time_ff    <= res_time_in;
      res_pct_ff     <= res_pct_in;
      if (rsp_load) begin
         rsp_matched_ff <= res_matched_ff;
         rsp_site_ff    <= res_site_ff;
         rsp_temp_ff    <= res_temp_ff;
         rsp_vib_ff     <= res_vib_ff;
         rsp_intr_ff    <= res_intr_ff;
         rsp_high_ff    <= res_high_ff;
         rsp_time_ff    <= res_time_ff;
         rsp_pct_ff     <= res_pct_ff;
      end
   end

   // Coordinate table: written by a load beat, read through a register at the scan index.
   always_ff @(posedge clock) begin
      if (coord_we) begin
         lat_mem[idx_addr] <= req_chan.latitude;
         lng_mem[idx_addr] <= req_chan.longitude;
      end
      lat_rd_ff <= lat_mem[coord_addr];
      lng_rd_ff <= lng_mem[coord_addr];
   end

   // Statistics table: an entry whose valid bit is clear reads as all zero.
   always_ff @(posedge clock) begin
      if (stat_we) begin
         temp_mem[stat_addr_ff] <= new_temp;
         vib_mem[stat_addr_ff]  <= new_vib;
         intr_mem[stat_addr_ff] <= new_intr;
         high_mem[stat_addr_ff] <= new_high;
         time_mem[stat_addr_ff] <= new_time;
      end
      temp_rd_ff <= temp_mem[stat_addr_in];
      vib_rd_ff  <= vib_mem[stat_addr_in];
      intr_rd_ff <= intr_mem[stat_addr_in];
      high_rd_ff <= high_mem[stat_addr_in];
      time_rd_ff <= time_mem[stat_addr_in];
      vld_rd_ff  <= stat_vld_ff[stat_addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_vld_ff <= '0;
      end else if (stat_we) begin
         stat_vld_ff[stat_addr_ff] <= 1'b1;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.matched      = rsp_matched_ff;
   assign rsp_chan.site         = rsp_site_ff;
   assign rsp_chan.temp_count   = rsp_temp_ff;
   assign rsp_chan.vib_count    = rsp_vib_ff;
   assign rsp_chan.intr_count   = rsp_intr_ff;
   assign rsp_chan.high_count   = rsp_high_ff;
   assign rsp_chan.latest_time  = rsp_time_ff;
   assign rsp_chan.risk_percent = rsp_pct_ff;

   // The percent unit only finishes while the sequencer waits for it.
   a_pct_done_in_wait: assert property (
      @(posedge clock) disable iff (reset)
      pct_status.done |-> (state_ff == ST_PCT)
   ) else $error("percent unit finished outside its wait state");

   // The scan never compares past the last site in use.
   a_scan_bounded: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (scan_ff <= last_ff)
   ) else $error("site scan ran past the last site in use");

   // An event with no sites in use goes straight to an unmatched result.
   a_drop_unmatched: assert property (
      @(posedge clock) disable iff (reset)
      (req_accept && req_chan.op == OP_EVENT && n_sites == '0)
         |=> (state_ff == ST_OUT && !res_matched_ff)
   ) else $error("event without sites was not dropped");

endmodule

FILE: design/nsb_dist_unit.sv
// Shared squaring unit: squares one difference per enabled cycle and keeps a running pair.
module nsb_dist_unit (
   input  logic                          clock,
   input  nsb_pkg::dist_ctrl_type        ctrl,
   input  logic signed [nsb_pkg::LAT_W-1:0] ev_lat,
   input  logic signed [nsb_pkg::LNG_W-1:0] ev_lng,
   input  logic signed [nsb_pkg::LAT_W-1:0] site_lat,
   input  logic signed [nsb_pkg::LNG_W-1:0] site_lng,
   output logic [nsb_pkg::DIST_W-1:0]    dist_sum
);
   import nsb_pkg::*;

   logic signed [DIFF_W-1:0] opa;
   logic signed [DIFF_W-1:0] opb;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        mag_full;
   logic [MAG_W-1:0]         mag;
   logic [SQ_W-1:0]          sq_ff;
   logic [SQ_W-1:0]          sum_ff;

   always_comb begin
      opa      = ctrl.use_lng ? DIFF_W'(ev_lng) : DIFF_W'(ev_lat);
      opb      = ctrl.use_lng ? DIFF_W'(site_lng) : DIFF_W'(site_lat);
      diff     = opa - opb;
      mag_full = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      mag      = mag_full[MAG_W-1:0];
   end

   // The previous square moves to sum_ff as the next one is formed.
   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         sq_ff  <= SQ_W'(mag) * SQ_W'(mag);
         sum_ff <= sq_ff;
      end
   end

   assign dist_sum = DIST_W'(sum_ff) + DIST_W'(sq_ff);

endmodule

FILE: design/nsb_pct_unit.sv
// Iterative risk percent unit: one restoring division step per cycle.
module nsb_pct_unit #(
   parameter int COUNT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [COUNT_BITS+1:0]   total,
   input  logic [COUNT_BITS-1:0]   high,
   output nsb_pkg::pct_status_type status
);
   import nsb_pkg::*;

   localparam int TOT_W = COUNT_BITS + 2;
   localparam int REM_W = COUNT_BITS + 6;
   localparam int DEN_W = TOT_W + QUO_W - 1;

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [STEP_W-1:0] step_ff,  step_in;
   logic [REM_W-1:0]  rem_ff,   rem_in;
   logic [DEN_W-1:0]  den_ff,   den_in;
   logic [QUO_W-1:0]  quo_ff,   quo_in;
   logic [PCT_W-1:0]  pct_ff,   pct_in;
   logic              fits;
   logic [QUO_W-1:0]  quo_next;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      pct_in   = pct_ff;
      fits     = (DEN_W'(rem_ff) >= den_ff);
      quo_next = {quo_ff[QUO_W-2:0], fits};

      if (start) begin
         // Percent is 50 + floor(50*high/total) when high is below total.
         if (total == '0) begin
            pct_in  = '0;
            done_in = 1'b1;
         end else if (TOT_W'(high) >= total) begin
            pct_in  = PCT_FULL;
            done_in = 1'b1;
         end else begin
            rem_in  = REM_W'(high) * REM_W'(PCT_HALF);
            den_in  = DEN_W'(total) << (QUO_W - 1);
            quo_in  = '0;
            step_in = STEP_W'(QUO_W - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - REM_W'(den_ff);
         end
         den_in = den_ff >> 1;
         quo_in = quo_next;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            pct_in  = PCT_HALF + PCT_W'(quo_next);
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      pct_ff  <= pct_in;
   end

   assign status.done = done_ff;
   assign status.pct  = pct_ff;

endmodule
